FILE: rtl/region_descriptor_table_macros.svh
// Assertion helpers shared by the region table RTL.
`ifndef REGION_DESCRIPTOR_TABLE_MACROS_SVH
`define REGION_DESCRIPTOR_TABLE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region table check failed");

// Next-cycle implication, held off during reset.
`define RDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region table check failed");

`endif

FILE: rtl/rdt_pkg.sv
`timescale 1ns / 1ps
package rdt_pkg;

    localparam int RDT_TABLE_SLOTS = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PUT   = 2'd1,
        OP_GET   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_ARG   = 3'd1,
        STAT_DUP       = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [63:0] model;
        logic [63:0] generation;
        logic [31:0] provider;
        logic [31:0] shard;
        logic [63:0] offset;
        logic [63:0] length;
    } t_desc;

    typedef struct packed {
        logic [63:0] key;
        t_desc       desc;
    } t_entry;

    typedef struct packed {
        t_status     status;
        t_desc       desc;
        logic [4:0]  entry_count;
    } t_result;

    typedef struct packed {
        logic clear;
        logic write;
    } t_store_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_CMP,
        S_DESC,
        S_WRITE,
        S_RESP
    } t_state;

endpackage

FILE: rtl/rdt_req_if.sv
`timescale 1ns / 1ps
interface rdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] region_key;
    logic [63:0] region_model;
    logic [63:0] region_generation;
    logic [31:0] region_provider;
    logic [31:0] region_shard;
    logic [63:0] region_offset;
    logic [63:0] region_length;

    modport source (
        output valid, opcode, region_key, region_model, region_generation,
               region_provider, region_shard, region_offset, region_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, region_key, region_model, region_generation,
               region_provider, region_shard, region_offset, region_length,
        output ready
    );
endinterface

FILE: rtl/rdt_rsp_if.sv
`timescale 1ns / 1ps
interface rdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] read_model;
    logic [63:0] read_generation;
    logic [31:0] read_provider;
    logic [31:0] read_shard;
    logic [63:0] read_offset;
    logic [63:0] read_length;
    logic [4:0]  entry_count;

    modport source (
        output valid, status, read_model, read_generation, read_provider,
               read_shard, read_offset, read_length, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, read_model, read_generation, read_provider,
               read_shard, read_offset, read_length, entry_count,
        output ready
    );
endinterface

FILE: rtl/rdt_store.sv
`timescale 1ns / 1ps
module rdt_store import rdt_pkg::*; #(
    parameter int TABLE_SLOTS = RDT_TABLE_SLOTS,
    parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    parameter int CNT_W       = $clog2(TABLE_SLOTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_entry,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_entry,
    output logic             o_rd_valid,
    output logic [CNT_W-1:0] o_count
);

    t_entry                 r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    t_entry                 r_rd_entry;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.write) begin
                r_valid[i_wr_addr] <= 1'b1;
                r_count            <= r_count + 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;
    assign o_count    = r_count;

endmodule

FILE: rtl/rdt_ctrl.sv
`timescale 1ns / 1ps
module rdt_ctrl import rdt_pkg::*; #(
    parameter int TABLE_SLOTS = RDT_TABLE_SLOTS,
    parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    parameter int CNT_W       = $clog2(TABLE_SLOTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rdt_req_if.sink          i_req,
    output t_store_ctl       o_store_ctl,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_entry           o_wr_entry,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_entry           i_rd_entry,
    input  logic             i_rd_valid,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    t_state           r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [63:0]      r_key, n_key;
    t_desc            r_desc, n_desc;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    t_status          r_status, n_status;
    t_desc            r_read, n_read;

    logic accept;
    logic key_hit;
    logic desc_eq;
    logic last_slot;
    logic bad_arg;

    assign accept    = i_req.valid && i_req.ready;
    // Two compares on the read entry: slot key in S_CMP, stored descriptor in S_DESC.
    assign key_hit   = i_rd_valid && (i_rd_entry.key == r_key);
    assign desc_eq   = (i_rd_entry.desc == r_desc);
    assign last_slot = (r_idx == IDX_W'(TABLE_SLOTS - 1));

    always_comb begin
        case (i_req.opcode)
            OP_CLEAR: bad_arg = 1'b0;
            OP_PUT:   bad_arg = (i_req.region_key == '0) || (i_req.region_length == '0);
            OP_GET:   bad_arg = (i_req.region_key == '0);
            default:  bad_arg = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.opcode == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (bad_arg) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_CLEAR: n_state = S_RESP;
            S_READ:  n_state = S_CMP;
            S_CMP: begin
                if (key_hit) begin
                    n_state = (r_op == OP_PUT) ? S_DESC : S_RESP;
                end else if (last_slot) begin
                    if ((r_op == OP_PUT) && (r_free_found || !i_rd_valid)) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            S_DESC:  n_state = S_RESP;
            S_WRITE: n_state = S_RESP;
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        i_req.ready       = 1'b0;
        o_store_ctl.clear = 1'b0;
        o_store_ctl.write = 1'b0;
        o_res_valid       = 1'b0;
        case (r_state)
            // hold off the input while in reset
            S_IDLE:  i_req.ready       = i_rst_n;
            S_CLEAR: o_store_ctl.clear = 1'b1;
            S_WRITE: o_store_ctl.write = 1'b1;
            S_RESP:  o_res_valid       = 1'b1;
            default: ;
        endcase
    end

    assign o_rd_addr         = r_idx;
    assign o_wr_addr         = r_free_idx;
    assign o_wr_entry.key    = r_key;
    assign o_wr_entry.desc   = r_desc;
    assign o_res.status      = r_status;
    assign o_res.desc        = r_read;
    assign o_res.entry_count = 5'(i_count);

    // Datapath
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_desc       = r_desc;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_status     = r_status;
        n_read       = r_read;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op              = i_req.opcode;
                    n_key             = i_req.region_key;
                    n_desc.model      = i_req.region_model;
                    n_desc.generation = i_req.region_generation;
                    n_desc.provider   = i_req.region_provider;
                    n_desc.shard      = i_req.region_shard;
                    n_desc.offset     = i_req.region_offset;
                    n_desc.length     = i_req.region_length;
                    n_idx             = '0;
                    n_free_found      = 1'b0;
                    n_read            = '0;
                    n_status          = STAT_BAD_ARG;
                end
            end
            S_CLEAR: n_status = STAT_OK;
            S_CMP: begin
                // remember the lowest free slot seen
                if (!i_rd_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if (key_hit) begin
                    if (r_op == OP_GET) begin
                        n_status = STAT_OK;
                        n_read   = i_rd_entry.desc;
                    end
                end else if (last_slot) begin
                    n_status = (r_op == OP_PUT) ? STAT_FULL : STAT_NOT_FOUND;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DESC:  n_status = desc_eq ? STAT_OK : STAT_DUP;
            S_WRITE: n_status = STAT_OK;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_desc       <= n_desc;
        r_idx        <= n_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_read       <= n_read;
    end

endmodule

FILE: rtl/region_descriptor_table.sv
// A rejected argument goes from accept straight to the response state, clear through S_CLEAR;
// put and get scan the slots in order until a key hit or the last slot.
// Put and get step one key compare through the slot memory, reading in S_READ and comparing in S_CMP.
// One request at a time: the next is taken once the result is in the output register.
// Reset clears the valid bits, the entry count and both handshakes.
`timescale 1ns / 1ps
`include "region_descriptor_table_macros.svh"
module region_descriptor_table import rdt_pkg::*; #(
    parameter int TABLE_SLOTS = RDT_TABLE_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdt_req_if.sink    i_req,
    rdt_rsp_if.source  o_rsp
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    t_store_ctl       w_ctl;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_entry;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_entry;
    logic             w_rd_valid;
    logic [CNT_W-1:0] w_count;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_res_ready;

    logic             r_out_valid;
    t_result          r_out;

    rdt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_store_ctl (w_ctl),
        .o_wr_addr   (w_wr_addr),
        .o_wr_entry  (w_wr_entry),
        .o_rd_addr   (w_rd_addr),
        .i_rd_entry  (w_rd_entry),
        .i_rd_valid  (w_rd_valid),
        .i_count     (w_count),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    rdt_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_wr_addr  (w_wr_addr),
        .i_wr_entry (w_wr_entry),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_rd_entry),
        .o_rd_valid (w_rd_valid),
        .o_count    (w_count)
    );

    // Output register: load when empty or being drained.
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.read_model      = r_out.desc.model;
    assign o_rsp.read_generation = r_out.desc.generation;
    assign o_rsp.read_provider   = r_out.desc.provider;
    assign o_rsp.read_shard      = r_out.desc.shard;
    assign o_rsp.read_offset     = r_out.desc.offset;
    assign o_rsp.read_length     = r_out.desc.length;
    assign o_rsp.entry_count     = r_out.entry_count;

    `RDT_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, w_count <= CNT_W'(TABLE_SLOTS))
    `RDT_ASSERT_NOW(a_read_zero, i_clk, i_rst_n, r_out_valid && (r_out.status != STAT_OK), r_out.desc == '0)
    `RDT_ASSERT_NEXT(a_write_count, i_clk, i_rst_n, w_ctl.write, w_count == $past(w_count) + 1'b1)
    `RDT_ASSERT_NEXT(a_clear_count, i_clk, i_rst_n, w_ctl.clear, w_count == '0)

endmodule
